// ===== hdl/stsc_pkg.sv =====
// ----------------------------------------------------------------------------
// stsc_pkg
// shared types, token kind codes and character constants of the token scanner
// ----------------------------------------------------------------------------
`default_nettype none

package stsc_pkg;

   // default position counter width
   localparam int POS_WIDTH_DEF = 16;

   // depth of the token queue between scanner and output
   localparam int QUEUE_DEPTH = 4;

   // token kinds
   localparam logic [2:0] KIND_INT    = 3'd0;
   localparam logic [2:0] KIND_IDENT  = 3'd1;
   localparam logic [2:0] KIND_STRING = 3'd2;
   localparam logic [2:0] KIND_DELIM  = 3'd3;
   localparam logic [2:0] KIND_UNTERM = 3'd4;
   localparam logic [2:0] KIND_BAD    = 3'd5;

   // saturation limit of integer tokens
   localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;

   // characters
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_TAB        = 8'h09;
   localparam logic [7:0] CH_CR         = 8'h0D;
   localparam logic [7:0] CH_ZERO       = 8'h30;
   localparam logic [7:0] CH_NINE       = 8'h39;
   localparam logic [7:0] CH_LOWER_A    = 8'h61;
   localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
   localparam logic [7:0] CH_UPPER_A    = 8'h41;
   localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_QUOTE      = 8'h27;
   localparam logic [7:0] CH_DOT        = 8'h2E;
   localparam logic [7:0] CH_EQUAL      = 8'h3D;
   localparam logic [7:0] CH_COMMA      = 8'h2C;
   localparam logic [7:0] CH_LPAREN     = 8'h28;
   localparam logic [7:0] CH_RPAREN     = 8'h29;

   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [2:0]  tok_kind;
      logic [15:0] tok_start;
      logic [15:0] tok_len;
      logic [30:0] int_value;
      logic        int_overflow;
      logic [7:0]  tok_char;
      logic        last_of_run;
   } rsp_type;

   // up to two tokens produced by one byte: the one it ends, the one it starts
   typedef struct packed {
      logic    a_valid;
      logic    b_valid;
      rsp_type a;
      rsp_type b;
   } tok_push_type;

   function automatic rsp_type make_tok(input logic [2:0]  kind,
                                        input logic [15:0] start,
                                        input logic [15:0] len,
                                        input logic [30:0] value,
                                        input logic        ovf,
                                        input logic [7:0]  c);
      rsp_type t;
      t.tok_kind     = kind;
      t.tok_start    = start;
      t.tok_len      = len;
      t.int_value    = value;
      t.int_overflow = ovf;
      t.tok_char     = c;
      t.last_of_run  = 1'b0;
      return t;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/stsc_front.sv =====
// ----------------------------------------------------------------------------
// stsc_front
// byte classifier and token state machine, one byte per cycle while in_valid is high
// ----------------------------------------------------------------------------
`default_nettype none

module stsc_front
   import stsc_pkg::*;
#(
   parameter int POS_WIDTH = POS_WIDTH_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   input  wire req_type      in_data,
   output tok_push_type      tok_push
);

   localparam logic [2:0] MODE_IDLE   = 3'd0;
   localparam logic [2:0] MODE_INT    = 3'd1;
   localparam logic [2:0] MODE_IDENT  = 3'd2;
   localparam logic [2:0] MODE_STRING = 3'd3;
   localparam logic [2:0] MODE_ERROR  = 3'd4;

   logic [2:0]           mode_ff,  mode_in;
   logic [POS_WIDTH-1:0] pos_ff,   pos_in;
   logic [POS_WIDTH-1:0] begin_ff, begin_in;
   logic [30:0]          acc_ff,   acc_in;
   logic                 sat_ff,   sat_in;

   logic [7:0] c;
   logic       eot;
   logic       is_space, is_digit, is_word, is_quote, is_delim;
   logic [3:0] digit;
   logic [34:0] prod;
   logic        over;
   logic [30:0] dig_acc;
   logic        dig_sat;

   logic [POS_WIDTH-1:0] len_before, len_with;
   logic [POS_WIDTH+15:0] pos_ext, begin_ext, lenb_ext, lenw_ext;
   logic [15:0] pos16, begin16, lenb16, lenw16;
   logic        do_start;

   assign c   = in_data.ch;
   assign eot = in_data.end_of_text;

   assign is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   assign is_digit = (c >= CH_ZERO && c <= CH_NINE);
   assign is_word  = (c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
                     (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c == CH_UNDERSCORE);
   assign is_quote = (c == CH_QUOTE);
   assign is_delim = (c == CH_DOT) || (c == CH_EQUAL) || (c == CH_COMMA) ||
                     (c == CH_LPAREN) || (c == CH_RPAREN);

   // acc*10 + digit by shift and add
   assign digit = c[3:0];
   assign prod  = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1) + {31'b0, digit};
   assign over  = prod > {4'b0, VALUE_MAX};
   assign dig_acc = over ? VALUE_MAX : prod[30:0];
   assign dig_sat = sat_ff | over;

   // positions and lengths wrap at the counter width, reported in 16 bits
   assign len_before = pos_ff - begin_ff;
   assign len_with   = pos_ff + 1'b1 - begin_ff;
   assign pos_ext    = {16'b0, pos_ff};
   assign begin_ext  = {16'b0, begin_ff};
   assign lenb_ext   = {16'b0, len_before};
   assign lenw_ext   = {16'b0, len_with};
   assign pos16      = pos_ext[15:0];
   assign begin16    = begin_ext[15:0];
   assign lenb16     = lenb_ext[15:0];
   assign lenw16     = lenw_ext[15:0];

   always_comb begin
      mode_in  = mode_ff;
      pos_in   = pos_ff;
      begin_in = begin_ff;
      acc_in   = acc_ff;
      sat_in   = sat_ff;
      do_start = 1'b0;
      tok_push.a_valid = 1'b0;
      tok_push.b_valid = 1'b0;
      tok_push.a = make_tok(KIND_INT, 16'd0, 16'd0, 31'd0, 1'b0, 8'd0);
      tok_push.b = make_tok(KIND_INT, 16'd0, 16'd0, 31'd0, 1'b0, 8'd0);

      if (in_valid) begin
         // token ended or continued by this byte
         case (mode_ff)
            MODE_INT: begin
               if (is_digit) begin
                  acc_in = dig_acc;
                  sat_in = dig_sat;
                  if (eot) begin
                     tok_push.a_valid = 1'b1;
                     tok_push.a = make_tok(KIND_INT, begin16, lenw16, dig_acc, dig_sat, 8'd0);
                  end
               end else begin
                  tok_push.a_valid = 1'b1;
                  tok_push.a = make_tok(KIND_INT, begin16, lenb16, acc_ff, sat_ff, 8'd0);
                  mode_in  = MODE_IDLE;
                  do_start = 1'b1;
               end
            end
            MODE_IDENT: begin
               if (is_word) begin
                  if (eot) begin
                     tok_push.a_valid = 1'b1;
                     tok_push.a = make_tok(KIND_IDENT, begin16, lenw16, 31'd0, 1'b0, 8'd0);
                  end
               end else begin
                  tok_push.a_valid = 1'b1;
                  tok_push.a = make_tok(KIND_IDENT, begin16, lenb16, 31'd0, 1'b0, 8'd0);
                  mode_in  = MODE_IDLE;
                  do_start = 1'b1;
               end
            end
            MODE_STRING: begin
               if (is_quote) begin
                  tok_push.a_valid = 1'b1;
                  tok_push.a = make_tok(KIND_STRING, begin16, lenw16, 31'd0, 1'b0, 8'd0);
                  mode_in = MODE_IDLE;
               end else if (eot) begin
                  tok_push.a_valid = 1'b1;
                  tok_push.a = make_tok(KIND_UNTERM, begin16, lenw16, 31'd0, 1'b0, 8'd0);
               end
            end
            MODE_IDLE: begin
               do_start = 1'b1;
            end
            default: begin
            end
         endcase

         // token started by this byte
         if (do_start && !is_space) begin
            begin_in = pos_ff;
            if (is_digit) begin
               acc_in  = {27'b0, digit};
               sat_in  = 1'b0;
               mode_in = MODE_INT;
               if (eot) begin
                  tok_push.b_valid = 1'b1;
                  tok_push.b = make_tok(KIND_INT, pos16, 16'd1, {27'b0, digit}, 1'b0, 8'd0);
               end
            end else if (is_word) begin
               mode_in = MODE_IDENT;
               if (eot) begin
                  tok_push.b_valid = 1'b1;
                  tok_push.b = make_tok(KIND_IDENT, pos16, 16'd1, 31'd0, 1'b0, 8'd0);
               end
            end else if (is_quote) begin
               mode_in = MODE_STRING;
               if (eot) begin
                  tok_push.b_valid = 1'b1;
                  tok_push.b = make_tok(KIND_UNTERM, pos16, 16'd1, 31'd0, 1'b0, 8'd0);
               end
            end else if (is_delim) begin
               tok_push.b_valid = 1'b1;
               tok_push.b = make_tok(KIND_DELIM, pos16, 16'd1, 31'd0, 1'b0, c);
            end else begin
               tok_push.b_valid = 1'b1;
               tok_push.b = make_tok(KIND_BAD, pos16, 16'd1, 31'd0, 1'b0, c);
               mode_in = MODE_ERROR;
            end
         end

         if (tok_push.b_valid) begin
            tok_push.b.last_of_run = 1'b1;
         end else if (tok_push.a_valid) begin
            tok_push.a.last_of_run = 1'b1;
         end

         // end of text starts a new text at position zero
         if (eot) begin
            mode_in  = MODE_IDLE;
            pos_in   = '0;
            begin_in = '0;
            acc_in   = '0;
            sat_in   = 1'b0;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         pos_ff   <= '0;
         begin_ff <= '0;
         acc_ff   <= '0;
         sat_ff   <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         begin_ff <= begin_in;
         acc_ff   <= acc_in;
         sat_ff   <= sat_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/stsc_queue.sv =====
// ----------------------------------------------------------------------------
// stsc_queue
// token queue, up to two writes and one read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module stsc_queue
   import stsc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire tok_push_type tok_push,
   input  wire logic         pop,
   output rsp_type           rsp_data,
   output logic              empty,
   output logic              full
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(QUEUE_DEPTH - 2);

   rsp_type entry_ff [QUEUE_DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic [PTR_W-1:0] wr_next;
   logic [1:0]       n_wr;
   logic             do_pop;
   rsp_type          first;

   assign wr_next = wr_ptr_ff + 1'b1;
   assign n_wr    = {1'b0, tok_push.a_valid} + {1'b0, tok_push.b_valid};
   assign first   = tok_push.a_valid ? tok_push.a : tok_push.b;
   assign empty   = (count_ff == '0);
   // room for two tokens is kept, whatever the next byte brings
   assign full    = (count_ff > ROOM_LIMIT);
   assign do_pop  = pop && !empty;
   assign rsp_data = entry_ff[rd_ptr_ff];

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(n_wr);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(do_pop);
   assign count_in  = count_ff + CNT_W'(n_wr) - CNT_W'(do_pop);

   always_ff @(posedge clock) begin
      if (n_wr != 2'd0) begin
         entry_ff[wr_ptr_ff] <= first;
      end
      if (n_wr == 2'd2) begin
         entry_ff[wr_next] <= tok_push.b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/sql_token_scanner.sv =====
// ----------------------------------------------------------------------------
// sql_token_scanner
// lexical scanner for sql statement text, one byte in, up to two tokens out
// ----------------------------------------------------------------------------
//  channel    ports                  direction  accepted when
//  request    push, full, req_data   in         push && !full
//  token      empty, pop, rsp_data   out        pop && !empty
//
//  one byte per clock while full is low; a byte's tokens enter the queue in the
//  same cycle and, if the queue was empty, the oldest one shows on rsp_data the
//  cycle after; the byte rate is set by the scanner state machine and by full;
//  a byte that ends one token and also forms a token of its own gives two tokens
//  full rises when the 4-entry queue has room for fewer than two tokens
//  reset is synchronous, active high, and returns to position zero, idle
// ----------------------------------------------------------------------------
`default_nettype none

module sql_token_scanner
   import stsc_pkg::*;
#(
   parameter int POS_WIDTH = POS_WIDTH_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   // request side
   input  wire logic    push,
   output logic         full,
   input  wire req_type req_data,
   // token side
   output logic         empty,
   input  wire logic    pop,
   output rsp_type      rsp_data
);

   logic         accept;
   tok_push_type tok_push;

   // a pushed byte is taken whenever the queue can absorb two tokens
   assign accept = push && !full;

   // front: classifies each byte and tracks the pending token
   stsc_front #(
      .POS_WIDTH (POS_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_data  (req_data),
      .tok_push (tok_push)
   );

   // back: queues finished tokens until popped
   stsc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .tok_push (tok_push),
      .pop      (pop),
      .rsp_data (rsp_data),
      .empty    (empty),
      .full     (full)
   );

`ifndef SYNTHESIS
   // tokens only come from an accepted byte
   assert property (@(posedge clock) disable iff (reset)
      (tok_push.a_valid || tok_push.b_valid) |-> accept)
      else $error("token produced without an accepted byte");

   // with two tokens from one byte only the second closes the run
   assert property (@(posedge clock) disable iff (reset)
      (tok_push.a_valid && tok_push.b_valid) |->
         (!tok_push.a.last_of_run && tok_push.b.last_of_run))
      else $error("last_of_run on the wrong token of a pair");

   // a single token from an accepted byte is marked last
   assert property (@(posedge clock) disable iff (reset)
      (tok_push.a_valid && !tok_push.b_valid) |-> tok_push.a.last_of_run)
      else $error("single token not marked last");

   // value and overflow belong to integer tokens only
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.tok_kind != KIND_INT) |->
         (rsp_data.int_value == 31'd0 && !rsp_data.int_overflow))
      else $error("integer value on a non-integer token");
`endif

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the sql token scanner: text bytes go in through the
// request queue port, every token that comes out is compared field by field
// with a local scanner model or a hand-written token; a short table of
// hand-written bytes comes first, then random texts
// ----------------------------------------------------------------------------
module tb;
   import stsc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // cycles without any accepted request or token before the run is abandoned
   localparam int STALL_LIMIT = 2000;
   // random requests to send after the directed part
   localparam int RANDOM_BYTES = 1320;

   localparam rsp_type NO_TOK = '0;

   // scanner states of the local model
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_INT    = 3'd1;
   localparam logic [2:0] ST_WORD   = 3'd2;
   localparam logic [2:0] ST_QUOTED = 3'd3;
   localparam logic [2:0] ST_SKIP   = 3'd4;

   // one request as offered to the block; typed rows carry hand-written tokens
   typedef struct {
      req_type r;
      bit      typed;
      int      n;
      rsp_type a;
      rsp_type b;
   } scan_row_type;

   logic    clock;
   logic    reset = 1'b1;
   logic    push = 1'b0;
   logic    full;
   req_type req_data = '0;
   logic    empty;
   logic    pop = 1'b0;
   rsp_type rsp_data;

   sql_token_scanner dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // local scanner model: its own copy of the scan state
   // ------------------------------------------------------------------
   logic [2:0]  sc_mode = ST_IDLE;
   logic [15:0] sc_pos = '0;
   logic [15:0] sc_begin = '0;
   logic [30:0] sc_value = '0;
   logic        sc_sat = 1'b0;

   // tokens produced by the byte just scanned, at most two
   rsp_type made [2];
   int      made_n;

   // tokens still owed by the block, oldest first
   rsp_type   tokens_due [$];
   // requests offered to the block and not yet accepted
   scan_row_type rows_offered [$];
   scan_row_type plan [$];
   logic [7:0] text_bytes [$];

   bit send_calm = 1'b0;
   bit take_calm = 1'b0;

   int fails = 0;
   int items_sent = 0;
   int texts_done = 0;
   int tokens_checked = 0;
   int saturated_seen = 0;
   int kind_seen [0:7];

   function automatic rsp_type tok(input logic [2:0] kind, input logic [15:0] start,
                                   input logic [15:0] len, input logic [30:0] value,
                                   input logic ovf, input logic [7:0] c,
                                   input logic last);
      rsp_type t;
      t.tok_kind     = kind;
      t.tok_start    = start;
      t.tok_len      = len;
      t.int_value    = value;
      t.int_overflow = ovf;
      t.tok_char     = c;
      t.last_of_run  = last;
      return t;
   endfunction

   function automatic bit is_blank(input logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic bit is_digit(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic bit is_word(input logic [7:0] c);
      return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z)
             || c == CH_UNDERSCORE;
   endfunction

   function automatic bit is_delim(input logic [7:0] c);
      return c == CH_DOT || c == CH_EQUAL || c == CH_COMMA || c == CH_LPAREN
             || c == CH_RPAREN;
   endfunction

   function automatic void emit(input rsp_type t);
      made[made_n] = t;
      made_n++;
   endfunction

   // decimal accumulate, sticking at the 31-bit maximum
   function automatic void add_digit(input logic [7:0] c);
      longint v;
      v = longint'(sc_value) * 10 + longint'(c - CH_ZERO);
      if (v > longint'(VALUE_MAX)) begin
         sc_value = VALUE_MAX;
         sc_sat   = 1'b1;
      end else begin
         sc_value = v[30:0];
      end
   endfunction

   // a byte seen between tokens
   function automatic void open_token(input logic [7:0] c, input logic [15:0] pos,
                                      input logic eot);
      if (!is_blank(c)) begin
         sc_begin = pos;
         if (is_digit(c)) begin
            sc_value = '0;
            sc_sat   = 1'b0;
            add_digit(c);
            sc_mode = ST_INT;
            if (eot) emit(tok(KIND_INT, pos, 16'd1, sc_value, sc_sat, 8'h00, 1'b0));
         end else if (is_word(c)) begin
            sc_mode = ST_WORD;
            if (eot) emit(tok(KIND_IDENT, pos, 16'd1, '0, 1'b0, 8'h00, 1'b0));
         end else if (c == CH_QUOTE) begin
            sc_mode = ST_QUOTED;
            if (eot) emit(tok(KIND_UNTERM, pos, 16'd1, '0, 1'b0, 8'h00, 1'b0));
         end else if (is_delim(c)) begin
            emit(tok(KIND_DELIM, pos, 16'd1, '0, 1'b0, c, 1'b0));
         end else begin
            // unknown byte: report it, then skip to end of text
            emit(tok(KIND_BAD, pos, 16'd1, '0, 1'b0, c, 1'b0));
            sc_mode = ST_SKIP;
         end
      end
   endfunction

   // work out the tokens one accepted byte gives and advance the model
   function automatic void scan_byte(input logic [7:0] c, input logic eot);
      logic [15:0] pos;
      logic [15:0] len_before;
      logic [15:0] len_with;
      pos        = sc_pos;
      len_before = pos - sc_begin;
      len_with   = pos + 16'd1 - sc_begin;
      made_n     = 0;
      case (sc_mode)
         ST_INT: begin
            if (is_digit(c)) begin
               add_digit(c);
               if (eot) emit(tok(KIND_INT, sc_begin, len_with, sc_value, sc_sat, 8'h00, 1'b0));
            end else begin
               emit(tok(KIND_INT, sc_begin, len_before, sc_value, sc_sat, 8'h00, 1'b0));
               sc_mode = ST_IDLE;
               open_token(c, pos, eot);
            end
         end
         ST_WORD: begin
            if (is_word(c)) begin
               if (eot) emit(tok(KIND_IDENT, sc_begin, len_with, '0, 1'b0, 8'h00, 1'b0));
            end else begin
               emit(tok(KIND_IDENT, sc_begin, len_before, '0, 1'b0, 8'h00, 1'b0));
               sc_mode = ST_IDLE;
               open_token(c, pos, eot);
            end
         end
         ST_QUOTED: begin
            // closing quote ends the string, quotes counted in the length
            if (c == CH_QUOTE) begin
               emit(tok(KIND_STRING, sc_begin, len_with, '0, 1'b0, 8'h00, 1'b0));
               sc_mode = ST_IDLE;
            end else if (eot) begin
               emit(tok(KIND_UNTERM, sc_begin, len_with, '0, 1'b0, 8'h00, 1'b0));
            end
         end
         ST_IDLE: open_token(c, pos, eot);
         default: ;
      endcase
      if (made_n > 0) made[made_n - 1].last_of_run = 1'b1;
      // end of text: next byte is position zero of a fresh text
      if (eot) begin
         sc_mode  = ST_IDLE;
         sc_pos   = '0;
         sc_begin = '0;
         sc_value = '0;
         sc_sat   = 1'b0;
      end else begin
         sc_pos = pos + 16'd1;
      end
   endfunction

   // ------------------------------------------------------------------
   // mismatch reporting and token compare
   // ------------------------------------------------------------------
   task automatic report(input string what);
      fails++;
      if (fails <= 30) $display("  mismatch: %s", what);
   endtask

   task automatic check_token(input rsp_type got, input rsp_type want);
      if (got.tok_kind != want.tok_kind)
         report($sformatf("token %0d kind %0d, want %0d",
                          tokens_checked, got.tok_kind, want.tok_kind));
      if (got.tok_start != want.tok_start)
         report($sformatf("token %0d start %0d, want %0d",
                          tokens_checked, got.tok_start, want.tok_start));
      if (got.tok_len != want.tok_len)
         report($sformatf("token %0d length %0d, want %0d",
                          tokens_checked, got.tok_len, want.tok_len));
      if (got.int_value != want.int_value)
         report($sformatf("token %0d value %0d, want %0d",
                          tokens_checked, got.int_value, want.int_value));
      if (got.int_overflow != want.int_overflow)
         report($sformatf("token %0d overflow %0b, want %0b",
                          tokens_checked, got.int_overflow, want.int_overflow));
      if (got.tok_char != want.tok_char)
         report($sformatf("token %0d char %02h, want %02h",
                          tokens_checked, got.tok_char, want.tok_char));
      if (got.last_of_run != want.last_of_run)
         report($sformatf("token %0d last flag %0b, want %0b",
                          tokens_checked, got.last_of_run, want.last_of_run));
   endtask

   // ------------------------------------------------------------------
   // monitor: both handshakes sampled at the rising edge; the accepted
   // request is scanned first so its tokens are owed before any pop
   // ------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      scan_row_type row;
      rsp_type      want;
      if (!reset) begin
         if (push && !full && rows_offered.size() > 0) begin
            row = rows_offered.pop_front();
            scan_byte(req_data.ch, req_data.end_of_text);
            if (req_data.end_of_text) texts_done++;
            // hand-written rows replace the model's tokens
            if (row.typed) begin
               if (row.n > 0) tokens_due.push_back(row.a);
               if (row.n > 1) tokens_due.push_back(row.b);
            end else begin
               for (int i = 0; i < made_n; i++) tokens_due.push_back(made[i]);
            end
         end
         if (pop && !empty) begin
            if (tokens_due.size() == 0) begin
               report($sformatf("token kind %0d at %0d with none owed",
                                rsp_data.tok_kind, rsp_data.tok_start));
            end else begin
               want = tokens_due.pop_front();
               check_token(rsp_data, want);
               kind_seen[want.tok_kind]++;
               if (want.int_overflow) saturated_seen++;
               tokens_checked++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // idling: mostly none or short, now and then long
   // ------------------------------------------------------------------
   function automatic int pick_gap(input bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // token side: pop in bursts with random stalls between them
   initial begin : token_taker
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = pick_gap(take_calm);
         if (stall > 0) begin
            pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         pop <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   // offer one request and hold it until the block takes it; push stays high
   // afterwards so back-to-back requests need no extra assignment
   task automatic send_item(input scan_row_type row);
      int gap;
      gap = pick_gap(send_calm);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      rows_offered.push_back(row);
      push     <= 1'b1;
      req_data <= row.r;
      do @(posedge clock); while (full);
      items_sent++;
   endtask

   task automatic send_plain(input logic [7:0] c, input logic eot);
      scan_row_type row;
      row.r.ch          = c;
      row.r.end_of_text = eot;
      row.typed         = 1'b0;
      row.n             = 0;
      row.a             = NO_TOK;
      row.b             = NO_TOK;
      send_item(row);
   endtask

   // one row of the directed table
   function automatic void plan_byte(input logic [7:0] c, input logic eot, input bit typed,
                                     input int n, input rsp_type a, input rsp_type b);
      scan_row_type row;
      row.r.ch          = c;
      row.r.end_of_text = eot;
      row.typed         = typed;
      row.n             = n;
      row.a             = a;
      row.b             = b;
      plan.push_back(row);
   endfunction

   function automatic logic [7:0] pick_letter();
      int r;
      r = $urandom_range(0, 52);
      if (r < 26) return CH_LOWER_A + 8'(r);
      if (r < 52) return CH_UPPER_A + 8'(r - 26);
      return CH_UNDERSCORE;
   endfunction

   function automatic logic [7:0] pick_blank();
      int r;
      r = $urandom_range(0, 5);
      if (r == 0) return CH_SPACE;
      return CH_TAB + 8'(r - 1);
   endfunction

   // any byte but a quote, for string bodies
   function automatic logic [7:0] pick_inside();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE);
      return c;
   endfunction

   // one random statement text into text_bytes: mostly well formed token
   // sequences, some ending broken, some plain noise
   function automatic void build_text();
      int shape;
      int len;
      logic [7:0] c;
      text_bytes.delete();
      shape = $urandom_range(0, 99);
      if (shape < 12) begin
         len = $urandom_range(1, 12);
         repeat (len) text_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
         if ($urandom_range(0, 3) == 0) text_bytes.push_back(pick_blank());
         repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 9))
               0, 1, 2: begin
                  len = $urandom_range(1, 6);
                  repeat (len) text_bytes.push_back(pick_letter());
               end
               3, 4, 5: begin
                  // long digit runs now and then, to reach saturation
                  len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 12)
                                                     : $urandom_range(1, 4);
                  repeat (len) text_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
               end
               6, 7: begin
                  text_bytes.push_back(CH_QUOTE);
                  len = $urandom_range(0, 5);
                  repeat (len) text_bytes.push_back(pick_inside());
                  text_bytes.push_back(CH_QUOTE);
               end
               default: begin
                  case ($urandom_range(0, 4))
                     0: text_bytes.push_back(CH_DOT);
                     1: text_bytes.push_back(CH_EQUAL);
                     2: text_bytes.push_back(CH_COMMA);
                     3: text_bytes.push_back(CH_LPAREN);
                     default: text_bytes.push_back(CH_RPAREN);
                  endcase
               end
            endcase
            repeat ($urandom_range(0, 2)) text_bytes.push_back(pick_blank());
         end
         if (shape >= 75) begin
            if ($urandom_range(0, 1) == 1) begin
               // string left open at end of text
               text_bytes.push_back(CH_QUOTE);
               len = $urandom_range(0, 4);
               repeat (len) text_bytes.push_back(pick_inside());
            end else begin
               // unknown byte, then junk that must be ignored
               do c = 8'($urandom_range(0, 255));
               while (is_blank(c) || is_digit(c) || is_word(c) || is_delim(c)
                      || c == CH_QUOTE);
               text_bytes.push_back(c);
               len = $urandom_range(0, 5);
               repeat (len) text_bytes.push_back(8'($urandom_range(0, 255)));
            end
         end
      end
   endfunction

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------
   initial begin : stimulus
      int random_start;
      foreach (kind_seen[k]) kind_seen[k] = 0;

      // directed table, positions counted from zero after reset
      // delimiter alone
      plan_byte(CH_LPAREN, 1'b0, 1'b1, 1,
                tok(KIND_DELIM, 16'd0, 16'd1, '0, 1'b0, CH_LPAREN, 1'b1), NO_TOK);
      // digit opens an integer, nothing yet
      plan_byte(CH_ZERO + 8'd7, 1'b0, 1'b1, 0, NO_TOK, NO_TOK);
      // one byte ends the integer and is a delimiter itself: two tokens
      plan_byte(CH_RPAREN, 1'b0, 1'b1, 2,
                tok(KIND_INT, 16'd1, 16'd1, 31'd7, 1'b0, 8'h00, 1'b0),
                tok(KIND_DELIM, 16'd2, 16'd1, '0, 1'b0, CH_RPAREN, 1'b1));
      plan_byte(CH_UPPER_Z, 1'b0, 1'b0, 0, NO_TOK, NO_TOK);
      plan_byte(CH_UNDERSCORE, 1'b0, 1'b0, 0, NO_TOK, NO_TOK);
      // tab ends the identifier
      plan_byte(CH_TAB, 1'b0, 1'b1, 1,
                tok(KIND_IDENT, 16'd3, 16'd2, '0, 1'b0, 8'h00, 1'b1), NO_TOK);
      // string holding the top byte value
      plan_byte(CH_QUOTE, 1'b0, 1'b0, 0, NO_TOK, NO_TOK);
      plan_byte(8'hFF, 1'b0, 1'b0, 0, NO_TOK, NO_TOK);
      plan_byte(CH_QUOTE, 1'b0, 1'b1, 1,
                tok(KIND_STRING, 16'd6, 16'd3, '0, 1'b0, 8'h00, 1'b1), NO_TOK);
      plan_byte(CH_EQUAL, 1'b0, 1'b0, 0, NO_TOK, NO_TOK);
      plan_byte(CH_COMMA, 1'b0, 1'b0, 0, NO_TOK, NO_TOK);
      plan_byte(CH_DOT, 1'b0, 1'b0, 0, NO_TOK, NO_TOK);
      // ten nines: saturates, flushed by end of text on the last digit
      repeat (9) plan_byte(CH_NINE, 1'b0, 1'b0, 0, NO_TOK, NO_TOK);
      plan_byte(CH_NINE, 1'b1, 1'b1, 1,
                tok(KIND_INT, 16'd12, 16'd10, VALUE_MAX, 1'b1, 8'h00, 1'b1), NO_TOK);
      // new text: a lone quote at end of text is an open string
      plan_byte(CH_QUOTE, 1'b1, 1'b1, 1,
                tok(KIND_UNTERM, 16'd0, 16'd1, '0, 1'b0, 8'h00, 1'b1), NO_TOK);
      // unknown byte, then the end-of-text byte is swallowed
      plan_byte(8'h00, 1'b0, 1'b1, 1,
                tok(KIND_BAD, 16'd0, 16'd1, '0, 1'b0, 8'h00, 1'b1), NO_TOK);
      plan_byte(8'hFF, 1'b1, 1'b1, 0, NO_TOK, NO_TOK);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) send_item(plan[i]);

      // random texts, each with its own idling style
      random_start = items_sent;
      while (items_sent - random_start < RANDOM_BYTES) begin
         send_calm = ($urandom_range(0, 7) == 0);
         take_calm = ($urandom_range(0, 7) == 0);
         build_text();
         foreach (text_bytes[i])
            send_plain(text_bytes[i], i == text_bytes.size() - 1);
      end
      push <= 1'b0;
      send_calm = 1'b0;
      take_calm = 1'b0;

      // let every owed token drain, then watch a little longer for strays
      while (tokens_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d bytes in %0d texts, directed rows first, then random texts",
               items_sent, texts_done);
      $display("checked %0d tokens: int %0d (%0d saturated), ident %0d, string %0d,",
               tokens_checked, kind_seen[KIND_INT], saturated_seen, kind_seen[KIND_IDENT],
               kind_seen[KIND_STRING]);
      $display("  delim %0d, open string %0d, unknown %0d",
               kind_seen[KIND_DELIM], kind_seen[KIND_UNTERM], kind_seen[KIND_BAD]);
      if (fails == 0) begin
         $display("sql_token_scanner test passed");
      end else begin
         $display("sql_token_scanner test failed");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // watchdog: too long with neither a request nor a token accepted
   // ------------------------------------------------------------------
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         if ((push && !full) || (pop && !empty)) idle = 0;
         else idle++;
      end
      $display("timeout: no request or token accepted in %0d cycles", STALL_LIMIT);
      $display("sql_token_scanner test failed");
      $finish;
   end

endmodule
